>>> hw/rtl/srecord_hex_encoder_assert.svh
// Assertion macros shared by the S-record encoder modules.
`ifndef SRECORD_HEX_ENCODER_ASSERT_SVH
`define SRECORD_HEX_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SHX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shx assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SHX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shx assertion failed");

`endif

>>> hw/rtl/shx_pkg.sv
// Shared types and constants of the S-record encoder.
package shx_pkg;

  localparam int RECORD_BYTES_DEF = 32;
  localparam int NAME_MAX_DEF     = 32;
  localparam int FIFO_DEPTH_DEF   = 4;

  // Longest character sequence that one item can cause.
  localparam int MAX_CHARS = 17;
  localparam int LEN_W     = $clog2(MAX_CHARS + 1);

  // Commands on the input channel.
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_NAME   = 2'd1;
  localparam logic [1:0] CMD_DATA   = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  // Configuration register indexes.
  localparam logic REG_NAME_LENGTH = 1'b0;
  localparam logic REG_DATA_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    JOB_ERR,
    JOB_START,
    JOB_NAME,
    JOB_DATA,
    JOB_FINISH
  } job_kind_t;

  // One queued output sequence, fully worked out by the front end.
  typedef struct packed {
    job_kind_t        kind;
    logic [LEN_W-1:0] len;     // number of characters
    logic             open;    // data: record header goes first
    logic             close;   // checksum and newline go last
    logic [7:0]       cnt;     // record byte count
    logic [31:0]      offset;  // data: record address
    logic [7:0]       data;    // name or data byte
    logic [7:0]       csum;    // final checksum
  } job_t;

endpackage

>>> hw/rtl/shx_front.sv
// Front end: accepts commands, tracks record state and queues output jobs.
module shx_front #(
  parameter int RECORD_BYTES = shx_pkg::RECORD_BYTES_DEF,
  parameter int NAME_MAX     = shx_pkg::NAME_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         q_full,
  output logic         q_push,
  output shx_pkg::job_t q_job
);
  import shx_pkg::*;

  localparam int MAXREC = (RECORD_BYTES > 250) ? 250 : RECORD_BYTES;
  localparam int CW     = $clog2(MAXREC + 1);
  localparam int NMAX   = (NAME_MAX > 63) ? 63 : NAME_MAX;

  typedef enum logic [1:0] {PH_IDLE, PH_NAME, PH_DATA} phase_t;

  phase_t          phase_r, phase_nxt;
  logic [5:0]      name_count_r, name_count_nxt;
  logic [31:0]     data_offset_r, data_offset_nxt;
  logic [CW-1:0]   chunk_fill_r, chunk_fill_nxt;
  logic [CW-1:0]   chunk_size_r, chunk_size_nxt;
  logic [7:0]      running_sum_r, running_sum_nxt;
  logic [5:0]      name_length_r;
  logic [31:0]     data_length_r;

  logic            accept;
  logic [5:0]      nl;
  logic [7:0]      start_cnt;
  logic [31:0]     rem;
  logic [CW-1:0]   size_use;
  logic [CW-1:0]   fill_inc;
  logic [7:0]      sum_new;
  logic            data_open;
  logic            data_close;
  job_t            job;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;
  assign q_job     = job;

  assign nl        = (name_length_r > 6'(NMAX)) ? 6'(NMAX) : name_length_r;
  assign start_cnt = {2'b00, nl} + 8'd3;
  assign rem       = data_length_r - data_offset_r;
  assign data_open = (chunk_fill_r == '0);
  assign size_use  = !data_open ? chunk_size_r :
                     (rem < 32'(MAXREC)) ? rem[CW-1:0] : CW'(MAXREC);
  assign fill_inc  = chunk_fill_r + CW'(1);
  assign data_close = (fill_inc >= size_use);

  always_comb begin
    phase_nxt       = phase_r;
    name_count_nxt  = name_count_r;
    data_offset_nxt = data_offset_r;
    chunk_fill_nxt  = chunk_fill_r;
    chunk_size_nxt  = chunk_size_r;
    running_sum_nxt = running_sum_r;
    sum_new         = 8'd0;
    job             = '0;
    job.kind        = JOB_ERR;
    job.len         = LEN_W'(1);
    job.data        = in_tdata;
    job.offset      = data_offset_r;
    case (in_tuser)
      CMD_START: begin
        if (phase_r == PH_IDLE) begin
          job.kind        = JOB_START;
          job.cnt         = start_cnt;
          job.close       = (nl == 6'd0);
          job.csum        = ~start_cnt;
          job.len         = (nl == 6'd0) ? LEN_W'(12) : LEN_W'(9);
          running_sum_nxt = start_cnt;
          data_offset_nxt = '0;
          chunk_fill_nxt  = '0;
          chunk_size_nxt  = '0;
          name_count_nxt  = nl;
          phase_nxt       = (nl == 6'd0) ? PH_DATA : PH_NAME;
        end
      end
      CMD_NAME: begin
        if (phase_r == PH_NAME && name_count_r != 6'd0) begin
          sum_new         = running_sum_r + in_tdata;
          job.kind        = JOB_NAME;
          job.close       = (name_count_r == 6'd1);
          job.csum        = ~sum_new;
          job.len         = (name_count_r == 6'd1) ? LEN_W'(5) : LEN_W'(2);
          running_sum_nxt = sum_new;
          name_count_nxt  = name_count_r - 6'd1;
          if (name_count_r == 6'd1) begin
            phase_nxt = PH_DATA;
          end
        end
      end
      CMD_DATA: begin
        if (phase_r == PH_DATA && (!data_open || data_offset_r < data_length_r)) begin
          job.cnt = 8'(size_use) + 8'd5;
          // A new record folds its count and four address bytes into the sum.
          if (data_open) begin
            sum_new = job.cnt + data_offset_r[31:24] + data_offset_r[23:16]
                      + data_offset_r[15:8] + data_offset_r[7:0] + in_tdata;
          end else begin
            sum_new = running_sum_r + in_tdata;
          end
          job.kind        = JOB_DATA;
          job.open        = data_open;
          job.close       = data_close;
          job.csum        = ~sum_new;
          job.len         = (data_open ? LEN_W'(12) : LEN_W'(0)) + LEN_W'(2)
                            + (data_close ? LEN_W'(3) : LEN_W'(0));
          running_sum_nxt = sum_new;
          chunk_size_nxt  = size_use;
          chunk_fill_nxt  = data_close ? '0 : fill_inc;
          data_offset_nxt = data_offset_r + 32'd1;
        end
      end
      default: begin
        if (phase_r == PH_DATA && data_open && data_offset_r >= data_length_r) begin
          job.kind        = JOB_FINISH;
          job.cnt         = 8'd5;
          job.close       = 1'b1;
          job.csum        = ~8'd5;
          job.len         = LEN_W'(15);
          phase_nxt       = PH_IDLE;
          name_count_nxt  = '0;
          data_offset_nxt = '0;
          chunk_fill_nxt  = '0;
          chunk_size_nxt  = '0;
          running_sum_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      name_count_r  <= '0;
      data_offset_r <= '0;
      chunk_fill_r  <= '0;
      chunk_size_r  <= '0;
      running_sum_r <= '0;
      name_length_r <= '0;
      data_length_r <= '0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        name_count_r  <= name_count_nxt;
        data_offset_r <= data_offset_nxt;
        chunk_fill_r  <= chunk_fill_nxt;
        chunk_size_r  <= chunk_size_nxt;
        running_sum_r <= running_sum_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NAME_LENGTH: name_length_r <= cfg_data[5:0];
          REG_DATA_LENGTH: data_length_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/shx_fifo.sv
// Short job queue between the front end and the character sequencer.
module shx_fifo #(
  parameter int DEPTH = shx_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  shx_pkg::job_t push_job,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output shx_pkg::job_t head_job
);
  import shx_pkg::*;
  `include "srecord_hex_encoder_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full_o   = (count_r == CW'(DEPTH));
  assign valid_o  = (count_r != '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  // The front end must hold off while the queue is full.
  `SHX_ASSERT_IMP(a_no_push_when_full, clk, rst_n, full_o, !push_i)

endmodule

>>> hw/rtl/shx_back.sv
// Back end: walks a queued job and emits its characters, one per beat.
module shx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  shx_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic          out_tuser
);
  import shx_pkg::*;
  `include "srecord_hex_encoder_assert.svh"

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_S  = "S";
  localparam logic [7:0] CH_0  = "0";
  localparam logic [7:0] CH_3  = "3";
  localparam logic [7:0] CH_5  = "5";
  localparam logic [7:0] CH_7  = "7";

  logic [LEN_W-1:0] idx_r;
  logic [LEN_W-1:0] pos;
  logic [7:0]       ch;
  logic             is_last;
  logic             load;
  logic             tvalid_r;
  logic [7:0]       tdata_r;
  logic             tlast_r, tuser_r;

  function automatic logic [7:0] hexc(input logic [3:0] n);
    hexc = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  assign is_last = (idx_r == q_job.len - LEN_W'(1));
  assign load    = q_valid && (!tvalid_r || out_tready);
  assign q_pop   = load && is_last;
  // Position within the byte-and-close tail of a data job.
  assign pos     = q_job.open ? idx_r - LEN_W'(12) : idx_r;

  always_comb begin
    ch = CH_NL;
    case (q_job.kind)
      JOB_ERR: ch = 8'h00;
      JOB_START: begin
        case (idx_r)
          LEN_W'(0): ch = CH_NL;
          LEN_W'(1): ch = CH_S;
          LEN_W'(2): ch = CH_0;
          LEN_W'(3): ch = hexc(q_job.cnt[7:4]);
          LEN_W'(4): ch = hexc(q_job.cnt[3:0]);
          LEN_W'(5), LEN_W'(6), LEN_W'(7), LEN_W'(8): ch = CH_0;
          LEN_W'(9): ch = hexc(q_job.csum[7:4]);
          LEN_W'(10): ch = hexc(q_job.csum[3:0]);
          default: ch = CH_NL;
        endcase
      end
      JOB_NAME: begin
        case (idx_r)
          LEN_W'(0): ch = hexc(q_job.data[7:4]);
          LEN_W'(1): ch = hexc(q_job.data[3:0]);
          LEN_W'(2): ch = hexc(q_job.csum[7:4]);
          LEN_W'(3): ch = hexc(q_job.csum[3:0]);
          default: ch = CH_NL;
        endcase
      end
      JOB_DATA: begin
        if (q_job.open && idx_r < LEN_W'(12)) begin
          case (idx_r)
            LEN_W'(0): ch = CH_S;
            LEN_W'(1): ch = CH_3;
            LEN_W'(2): ch = hexc(q_job.cnt[7:4]);
            LEN_W'(3): ch = hexc(q_job.cnt[3:0]);
            LEN_W'(4): ch = hexc(q_job.offset[31:28]);
            LEN_W'(5): ch = hexc(q_job.offset[27:24]);
            LEN_W'(6): ch = hexc(q_job.offset[23:20]);
            LEN_W'(7): ch = hexc(q_job.offset[19:16]);
            LEN_W'(8): ch = hexc(q_job.offset[15:12]);
            LEN_W'(9): ch = hexc(q_job.offset[11:8]);
            LEN_W'(10): ch = hexc(q_job.offset[7:4]);
            default: ch = hexc(q_job.offset[3:0]);
          endcase
        end else begin
          case (pos)
            LEN_W'(0): ch = hexc(q_job.data[7:4]);
            LEN_W'(1): ch = hexc(q_job.data[3:0]);
            LEN_W'(2): ch = hexc(q_job.csum[7:4]);
            LEN_W'(3): ch = hexc(q_job.csum[3:0]);
            default: ch = CH_NL;
          endcase
        end
      end
      JOB_FINISH: begin
        case (idx_r)
          LEN_W'(0): ch = CH_S;
          LEN_W'(1): ch = CH_7;
          LEN_W'(2): ch = CH_0;
          LEN_W'(3): ch = CH_5;
          LEN_W'(12): ch = hexc(q_job.csum[7:4]);
          LEN_W'(13): ch = hexc(q_job.csum[3:0]);
          LEN_W'(14): ch = CH_NL;
          default: ch = CH_0;
        endcase
      end
      default: ch = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (load) begin
        tvalid_r <= 1'b1;
        idx_r    <= is_last ? '0 : idx_r + LEN_W'(1);
      end else if (out_tready) begin
        tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= ch;
      tlast_r <= is_last;
      tuser_r <= (q_job.kind == JOB_ERR);
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_tdata  = tdata_r;
  assign out_tlast  = tlast_r;
  assign out_tuser  = tuser_r;

  // The character index never runs past the end of the job at the head.
  `SHX_ASSERT_IMP(a_idx_in_range, clk, rst_n, q_valid, idx_r < q_job.len)
  // A rejected item gives a single beat that also closes its sequence.
  `SHX_ASSERT_IMP(a_err_is_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  // A sequence is only popped on its final character.
  `SHX_ASSERT_NXT(a_pop_marks_last, clk, rst_n, q_pop, out_tvalid && out_tlast)

endmodule

>>> hw/rtl/srecord_hex_encoder.sv
// Top level of the Motorola S-record (S0/S3/S7) text encoder.
//
// Input channel: one command per beat. in_tuser carries the command (start,
// name byte, data byte, finish) and in_tdata the byte for name and data beats.
// Output channel: one ASCII character per beat on out_tdata; out_tlast marks
// the final character caused by one input beat, out_tuser flags a rejected
// command, which yields a single character of zero.
// Configuration: cfg_index selects name_length (0) or data_length (1); writes
// are taken in any cycle and belong between streams.
// Timing: a command is classified in the cycle it is accepted and its job is
// queued at the accepting edge; the first character is then registered onto
// out_tdata from the head of the queue. The character sequencer emits one
// character a cycle while the receiver does not stall, and an item has 2
// characters for a plain data byte, 5 when it closes a record, 17 when it also
// opens one, up to 15 for start and finish. The queue holds FIFO_DEPTH jobs,
// so commands are accepted ahead while characters drain.
// Reset clears the record state, the registers and the queue. When the
// receiver stalls, the current character holds, the queue fills and in_tready
// drops once it is full.
module srecord_hex_encoder #(
  parameter int RECORD_BYTES = shx_pkg::RECORD_BYTES_DEF,
  parameter int NAME_MAX     = shx_pkg::NAME_MAX_DEF,
  parameter int FIFO_DEPTH   = shx_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // character[7:0]
  output logic        out_tlast,
  output logic        out_tuser,  // error[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import shx_pkg::*;

  logic push, full, pop, head_valid;
  job_t push_job, head_job;

  shx_front #(
    .RECORD_BYTES(RECORD_BYTES),
    .NAME_MAX    (NAME_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (full),
    .q_push   (push),
    .q_job    (push_job)
  );

  shx_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .push_job(push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_job(head_job)
  );

  shx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_job     (head_job),
    .q_pop     (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the S-record text encoder: directed and random command streams.
module testbench;
  import shx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 24;
  localparam int ITEM_TARGET = 330;
  localparam int QUIET_ITEMS = 60;

  typedef enum logic [1:0] {PH_IDLE, PH_NAME, PH_DATA} stream_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } text_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  text_beat_t    expected_text[$];
  logic [7:0]    char_buf[$];

  // Encoder state as the testbench sees it.
  logic [5:0]    name_len_reg;
  logic [31:0]   data_len_reg;
  stream_phase_t str_phase;
  logic [5:0]    names_left;
  logic [31:0]   byte_offset;
  logic [7:0]    rec_fill;
  logic [7:0]    rec_size;
  logic [7:0]    csum_acc;

  int error_count;
  int items_sent;
  int cycle_count;
  int stall_left;
  bit idle_on;

  srecord_hex_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  function automatic void put_hex(input logic [7:0] b);
    char_buf.push_back(hex_char(b[7:4]));
    char_buf.push_back(hex_char(b[3:0]));
  endfunction

  function automatic void put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
  endfunction

  function automatic void put_close();
    put_hex(8'hff - csum_acc);
    char_buf.push_back(8'h0a);
  endfunction

  // Works out the characters that one command produces and queues them.
  function automatic void encode_command(input logic [1:0] cmd, input logic [7:0] b);
    logic        ok;
    logic [5:0]  nl;
    logic [31:0] rem;
    int          sh;
    int          i;
    ok = 1'b0;
    char_buf.delete();
    case (cmd)
      CMD_START: if (str_phase == PH_IDLE) begin
        nl = (name_len_reg > NAME_MAX_DEF) ? 6'(NAME_MAX_DEF) : name_len_reg;
        char_buf.push_back(8'h0a);
        put_text("S0");
        put_hex({2'b00, nl} + 8'd3);
        put_text("0000");
        csum_acc = {2'b00, nl} + 8'd3;
        byte_offset = '0;
        rec_fill = '0;
        rec_size = '0;
        if (nl == 6'd0) begin
          put_close();
          str_phase = PH_DATA;
          names_left = '0;
        end else begin
          str_phase = PH_NAME;
          names_left = nl;
        end
        ok = 1'b1;
      end
      CMD_NAME: if (str_phase == PH_NAME && names_left != 6'd0) begin
        put_hex(b);
        csum_acc += b;
        names_left--;
        if (names_left == 6'd0) begin
          put_close();
          str_phase = PH_DATA;
        end
        ok = 1'b1;
      end
      CMD_DATA: if (str_phase == PH_DATA &&
                    (rec_fill != 8'd0 || byte_offset < data_len_reg)) begin
        if (rec_fill == 8'd0) begin
          // The record size is fixed here, from what is left of the data length.
          rem = data_len_reg - byte_offset;
          rec_size = (rem < RECORD_BYTES_DEF) ? rem[7:0] : 8'(RECORD_BYTES_DEF);
          put_text("S3");
          put_hex(rec_size + 8'd5);
          csum_acc = rec_size + 8'd5;
          for (sh = 24; sh >= 0; sh -= 8) begin
            put_hex(byte_offset[sh +: 8]);
            csum_acc += byte_offset[sh +: 8];
          end
        end
        put_hex(b);
        csum_acc += b;
        rec_fill++;
        byte_offset++;
        if (rec_fill >= rec_size) begin
          put_close();
          rec_fill = '0;
        end
        ok = 1'b1;
      end
      CMD_FINISH: if (str_phase == PH_DATA && rec_fill == 8'd0 &&
                      byte_offset >= data_len_reg) begin
        put_text("S70500000000");
        csum_acc = 8'd5;
        put_close();
        str_phase = PH_IDLE;
        names_left = '0;
        byte_offset = '0;
        rec_fill = '0;
        rec_size = '0;
        csum_acc = '0;
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      expected_text.push_back('{ch: 8'h00, last: 1'b1, err: 1'b1});
    end else begin
      for (i = 0; i < char_buf.size(); i++)
        expected_text.push_back('{ch: char_buf[i], last: (i == char_buf.size() - 1), err: 1'b0});
    end
  endfunction

  task automatic send_command(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = b;
    encode_command(cmd, b);
    items_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_noise();
    send_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_text();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NAME_LENGTH) name_len_reg = val[5:0];
    else data_len_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Brings the encoder back to idle from wherever the stream left it.
  task automatic close_stream();
    while (str_phase == PH_NAME) send_command(CMD_NAME, 8'($urandom_range(0, 255)));
    while (rec_fill != 8'd0) send_command(CMD_DATA, 8'($urandom_range(0, 255)));
    if (str_phase == PH_DATA && byte_offset < data_len_reg) begin
      wait_for_text();
      write_reg(REG_DATA_LENGTH, byte_offset);
    end
    if (str_phase == PH_DATA) send_command(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    write_reg(REG_NAME_LENGTH, 32'd0);
    write_reg(REG_DATA_LENGTH, 32'd0);
    // Every command is out of order while idle, except start.
    send_command(CMD_FINISH, 8'h00);
    send_command(CMD_NAME, 8'hff);
    send_command(CMD_DATA, 8'h5a);
    send_command(CMD_START, 8'hff);
    send_command(CMD_START, 8'h00);
    send_command(CMD_NAME, 8'h12);
    send_command(CMD_DATA, 8'h34);
    send_command(CMD_FINISH, 8'hff);
    wait_for_text();
    write_reg(REG_NAME_LENGTH, 32'd2);
    write_reg(REG_DATA_LENGTH, 32'd3);
    send_command(CMD_START, 8'h00);
    send_command(CMD_DATA, 8'h11);
    send_command(CMD_FINISH, 8'h00);
    send_command(CMD_NAME, 8'h00);
    send_command(CMD_NAME, 8'hff);
    send_command(CMD_NAME, 8'h77);
    send_command(CMD_DATA, 8'h00);
    send_command(CMD_FINISH, 8'h00);
    send_command(CMD_DATA, 8'hff);
    send_command(CMD_DATA, 8'ha5);
    send_command(CMD_DATA, 8'h3c);
    send_command(CMD_FINISH, 8'h00);
    wait_for_text();
  endtask

  task automatic test_clamped_name();
    int i;
    write_reg(REG_NAME_LENGTH, 32'd63);
    write_reg(REG_DATA_LENGTH, 32'd40);
    send_command(CMD_START, 8'($urandom_range(0, 255)));
    for (i = 0; i < NAME_MAX_DEF; i++) send_command(CMD_NAME, 8'($urandom_range(0, 255)));
    send_command(CMD_NAME, 8'($urandom_range(0, 255)));
    for (i = 0; i < 40; i++) send_command(CMD_DATA, 8'($urandom_range(0, 255)));
    send_command(CMD_DATA, 8'($urandom_range(0, 255)));
    send_command(CMD_FINISH, 8'($urandom_range(0, 255)));
    wait_for_text();
  endtask

  // Shrinks the data length while a record is open; that record still fills up.
  task automatic test_open_record_rewrite();
    int i;
    write_reg(REG_NAME_LENGTH, 32'd1);
    write_reg(REG_DATA_LENGTH, 32'hffff_ffff);
    send_command(CMD_START, 8'($urandom_range(0, 255)));
    send_command(CMD_NAME, 8'($urandom_range(0, 255)));
    for (i = 0; i < 40; i++) send_command(CMD_DATA, 8'($urandom_range(0, 255)));
    wait_for_text();
    write_reg(REG_DATA_LENGTH, 32'd50);
    while (rec_fill != 8'd0) send_command(CMD_DATA, 8'($urandom_range(0, 255)));
    send_command(CMD_DATA, 8'($urandom_range(0, 255)));
    send_command(CMD_FINISH, 8'($urandom_range(0, 255)));
    wait_for_text();
  endtask

  task automatic test_random_streams();
    logic [31:0] nl;
    logic [31:0] dl;
    int          n_names;
    int          n_data;
    int          i;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - QUIET_ITEMS) idle_on = 1'b0;
      wait_for_text();
      case ($urandom_range(0, 9))
        0:       nl = 32'd0;
        1:       nl = $urandom_range(33, 63);
        2:       nl = 32'd32;
        default: nl = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0:       dl = 32'd0;
        1:       dl = $urandom();
        2:       dl = $urandom_range(33, 70);
        default: dl = $urandom_range(1, 20);
      endcase
      write_reg(REG_DATA_LENGTH, dl);
      write_reg(REG_NAME_LENGTH, nl);
      n_names = (nl > NAME_MAX_DEF) ? NAME_MAX_DEF : nl;
      n_data  = (dl > 70) ? $urandom_range(1, 40) : dl;
      send_command(CMD_START, 8'($urandom_range(0, 255)));
      for (i = 0; i < n_names; i++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        send_command(CMD_NAME, 8'($urandom_range(0, 255)));
      end
      for (i = 0; i < n_data; i++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        send_command(CMD_DATA, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 5) == 0) send_noise();
      send_command(CMD_FINISH, 8'($urandom_range(0, 255)));
      close_stream();
    end
  endtask

  // Receiver side: stalls in short bursts while idling is enabled.
  always @(negedge clk) begin
    if (!idle_on) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    text_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected beat: char %h last %b error %b", $time,
                 out_tdata, out_tlast, out_tuser);
        error_count++;
      end else begin
        want = expected_text.pop_front();
        if (out_tdata !== want.ch) begin
          $display("%0t: character mismatch: expected %h actual %h", $time, want.ch, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch: expected %b actual %b", $time, want.last, out_tlast);
          error_count++;
        end
        if (out_tuser !== want.err) begin
          $display("%0t: error flag mismatch: expected %b actual %b", $time, want.err, out_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_START;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_NAME_LENGTH;
    cfg_data     = '0;
    name_len_reg = '0;
    data_len_reg = '0;
    str_phase    = PH_IDLE;
    names_left   = '0;
    byte_offset  = '0;
    rec_fill     = '0;
    rec_size     = '0;
    csum_acc     = '0;
    error_count  = 0;
    items_sent   = 0;
    cycle_count  = 0;
    stall_left   = 0;
    idle_on      = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_clamped_name();
    test_open_record_rewrite();
    test_random_streams();

    wait_for_text();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> srecord_hex_encoder.f
+incdir+hw/rtl
hw/rtl/shx_pkg.sv
hw/rtl/shx_front.sv
hw/rtl/shx_fifo.sv
hw/rtl/shx_back.sv
hw/rtl/srecord_hex_encoder.sv
test/testbench.sv
